### rtl/ccu_pkg.sv
// Shared widths and limits for the composition code unranker.
package ccu_pkg;

   localparam int ACTION_LIMIT = 8;
   localparam int MAX_UNITS    = 256;

   localparam int CODE_W  = 48;
   localparam int ACT_W   = 4;
   localparam int IDX_W   = 3;
   localparam int UNIT_W  = 9;

   localparam int COL_DEPTH = ACTION_LIMIT - 1;
   localparam int COL_IDX_W = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
   localparam int STEP_W    = $clog2(MAX_UNITS + ACTION_LIMIT - 1);

endpackage

### rtl/composition_code_unrank.sv
// Composition unranker top level: rank code to per-action unit counts.
//
// Usage: load the unit total through csr_wr_en/csr_wr_data while busy is low.
// A transfer on the request side happens when start is high and busy is low;
// req_rank_code and req_action_count are sampled then. The block answers with
// one result per action, in action order, each on the rsp_ ports for exactly
// one cycle while rsp_valid is high; rsp_last_action marks the final one and
// busy is low from that same cycle on. The receiver cannot stall the block.
// Datapath: one shared 49-bit add/subtract unit does all the work. A column of
// binomials C(n, j), j up to K = actions - 2, is first built by Pascal steps.
// Each unit granted then subtracts a column entry from the code and, while k
// is nonzero, updates the column; each move to the next action lowers k by
// one and updates the column unless k reaches zero, k being the current column
// depth. A single-action request goes straight to its final result.
// One request is in flight at a time.
// Reset: the unit total returns to 1, the block goes idle, no result pending.
module composition_code_unrank
   import ccu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CODE_W-1:0] req_rank_code,
   input  logic [ACT_W-1:0]  req_action_count,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_action_index,
   output logic [UNIT_W-1:0] rsp_unit_count,
   output logic              rsp_last_action,
   input  logic              csr_wr_en,
   input  logic [UNIT_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_TRY,
      ST_DEC,
      ST_LAST
   } state_type;

   state_type              state_ff;
   logic [UNIT_W-1:0]      total_ff;
   logic [CODE_W-1:0]      code_ff;
   logic [CODE_W-1:0]      col_ff [COL_DEPTH];
   logic [CODE_W-1:0]      carry_ff;
   logic [COL_IDX_W-1:0]   k_ff;
   logic [COL_IDX_W-1:0]   j_ff;
   logic [COL_IDX_W-1:0]   jmax_ff;
   logic [STEP_W-1:0]      steps_ff;
   logic [UNIT_W-1:0]      left_ff;
   logic [UNIT_W-1:0]      cnt_ff;
   logic [IDX_W-1:0]       act_ff;
   logic                   rsp_valid_ff;
   logic [IDX_W-1:0]       rsp_idx_ff;
   logic [UNIT_W-1:0]      rsp_cnt_ff;
   logic                   rsp_last_ff;

   logic [ACT_W-1:0]       acts_sat;
   logic [UNIT_W-1:0]      units_sat;
   logic [COL_IDX_W-1:0]   k_init;
   logic [COL_IDX_W-1:0]   rd_idx;
   logic [CODE_W-1:0]      rd_val;
   logic [CODE_W-1:0]      alu_a;
   logic [CODE_W-1:0]      alu_b;
   logic [CODE_W:0]        alu_res;

   always_comb begin
      if (req_action_count == '0) begin
         acts_sat = ACT_W'(1);
      end else if (req_action_count > ACT_W'(ACTION_LIMIT)) begin
         acts_sat = ACT_W'(ACTION_LIMIT);
      end else begin
         acts_sat = req_action_count;
      end
      units_sat = (total_ff > UNIT_W'(MAX_UNITS)) ? UNIT_W'(MAX_UNITS) : total_ff;
      k_init    = COL_IDX_W'(acts_sat - ACT_W'(2));
      rd_idx    = (state_ff == ST_TRY) ? k_ff : j_ff;
      rd_val    = col_ff[rd_idx];
      alu_a     = (state_ff == ST_TRY) ? code_ff : rd_val;
      alu_b     = (state_ff == ST_TRY) ? rd_val : carry_ff;
      if (state_ff == ST_BUILD) begin
         alu_res = {1'b0, alu_a} + {1'b0, alu_b};
      end else begin
         alu_res = {1'b0, alu_a} - {1'b0, alu_b};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= UNIT_W'(1);
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  code_ff  <= req_rank_code;
                  left_ff  <= units_sat;
                  cnt_ff   <= '0;
                  act_ff   <= '0;
                  carry_ff <= CODE_W'(1);
                  j_ff     <= COL_IDX_W'(1);
                  col_ff[0] <= CODE_W'(1);
                  for (int i = 1; i < COL_DEPTH; i++) begin
                     col_ff[i] <= '0;
                  end
                  k_ff     <= k_init;
                  steps_ff <= STEP_W'(units_sat) + STEP_W'(k_init);
                  if (acts_sat == ACT_W'(1)) begin
                     state_ff <= ST_LAST;
                  end else if (k_init == '0) begin
                     state_ff <= ST_TRY;
                  end else begin
                     state_ff <= ST_BUILD;
                  end
               end
            end
            ST_BUILD: begin
               rsp_valid_ff <= 1'b0;
               col_ff[j_ff] <= alu_res[CODE_W-1:0];
               if (j_ff == k_ff) begin
                  j_ff     <= COL_IDX_W'(1);
                  carry_ff <= CODE_W'(1);
                  steps_ff <= steps_ff - STEP_W'(1);
                  if (steps_ff == STEP_W'(1)) begin
                     state_ff <= ST_TRY;
                  end
               end else begin
                  j_ff     <= j_ff + COL_IDX_W'(1);
                  carry_ff <= rd_val;
               end
            end
            ST_TRY: begin
               if (left_ff != '0 && !alu_res[CODE_W]) begin
                  rsp_valid_ff <= 1'b0;
                  code_ff <= alu_res[CODE_W-1:0];
                  cnt_ff  <= cnt_ff + UNIT_W'(1);
                  left_ff <= left_ff - UNIT_W'(1);
                  if (k_ff != '0) begin
                     j_ff     <= COL_IDX_W'(1);
                     jmax_ff  <= k_ff;
                     carry_ff <= CODE_W'(1);
                     state_ff <= ST_DEC;
                  end
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= act_ff;
                  rsp_cnt_ff   <= cnt_ff;
                  rsp_last_ff  <= 1'b0;
                  act_ff       <= act_ff + IDX_W'(1);
                  cnt_ff       <= '0;
                  if (k_ff == '0) begin
                     state_ff <= ST_LAST;
                  end else begin
                     k_ff <= k_ff - COL_IDX_W'(1);
                     if (k_ff == COL_IDX_W'(1)) begin
                        state_ff <= ST_TRY;
                     end else begin
                        j_ff     <= COL_IDX_W'(1);
                        jmax_ff  <= k_ff - COL_IDX_W'(1);
                        carry_ff <= CODE_W'(1);
                        state_ff <= ST_DEC;
                     end
                  end
               end
            end
            ST_DEC: begin
               rsp_valid_ff <= 1'b0;
               col_ff[j_ff] <= alu_res[CODE_W-1:0];
               carry_ff     <= alu_res[CODE_W-1:0];
               if (j_ff == jmax_ff) begin
                  state_ff <= ST_TRY;
               end else begin
                  j_ff <= j_ff + COL_IDX_W'(1);
               end
            end
            ST_LAST: begin
               rsp_valid_ff <= 1'b1;
               rsp_idx_ff   <= act_ff;
               rsp_cnt_ff   <= left_ff;
               rsp_last_ff  <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action_index = rsp_idx_ff;
   assign rsp_unit_count   = rsp_cnt_ff;
   assign rsp_last_action  = rsp_last_ff;

endmodule

### rtl/ccu_checker.sv
// Port-level checks for the composition unranker, bound to its top level.
module ccu_checker
   import ccu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [IDX_W-1:0]  rsp_action_index,
   input logic [UNIT_W-1:0] rsp_unit_count,
   input logic              rsp_last_action
);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_action) |-> !busy)
      else $error("busy still high on final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_action) |-> busy)
      else $error("non-final result while idle");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_count <= UNIT_W'(MAX_UNITS)))
      else $error("unit count above limit");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_action) |=>
         (!rsp_valid || rsp_action_index == $past(rsp_action_index) + IDX_W'(1)))
      else $error("action index did not advance");

endmodule

bind composition_code_unrank ccu_checker u_ccu_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_action_index (rsp_action_index),
   .rsp_unit_count   (rsp_unit_count),
   .rsp_last_action  (rsp_last_action)
);

### dv/composition_code_unrank_checker.sv
// Checker for the composition unranker: predicts per-action unit counts and compares results.
module composition_code_unrank_checker
   import ccu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [CODE_W-1:0] req_rank_code,
   input  logic [ACT_W-1:0]  req_action_count,
   input  logic              rsp_valid,
   input  logic [IDX_W-1:0]  rsp_action_index,
   input  logic [UNIT_W-1:0] rsp_unit_count,
   input  logic              rsp_last_action,
   input  logic              csr_wr_en,
   input  logic [UNIT_W-1:0] csr_wr_data,
   output int                error_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned BINOM_CAP = 64'd1 << CODE_W;

   typedef struct packed {
      logic [IDX_W-1:0]  action;
      logic [UNIT_W-1:0] units;
      logic              is_last;
   } share_type;

   share_type         expected_shares[$];
   logic [UNIT_W-1:0] unit_total;

   function automatic longint unsigned choose_capped(longint unsigned n,
                                                     longint unsigned k);
      longint unsigned acc;
      longint unsigned kk;
      acc = 1;
      kk  = k;
      if (kk > n) return 0;
      if (kk > n - kk) kk = n - kk;
      for (longint unsigned i = 1; i <= kk; i++) begin
         acc = acc * (n - kk + i) / i;
         if (acc > BINOM_CAP) acc = BINOM_CAP;
      end
      return acc;
   endfunction

   task automatic split_units(input logic [CODE_W-1:0] code_in,
                              input logic [ACT_W-1:0]  acts_in);
      longint unsigned code;
      longint unsigned skip;
      int              units;
      int              acts;
      int              remain;
      int              cnt;
      int              later;
      share_type       s;
      code   = 64'(code_in);
      units  = (unit_total > MAX_UNITS) ? MAX_UNITS : int'(unit_total);
      acts   = int'(acts_in);
      if (acts < 1) acts = 1;
      if (acts > ACTION_LIMIT) acts = ACTION_LIMIT;
      remain = units;
      for (int a = 0; a + 1 < acts; a++) begin
         later = acts - a - 1;
         cnt   = 0;
         while (cnt < remain) begin
            skip = choose_capped(remain - cnt + later - 1, later - 1);
            if (code < skip) break;
            code -= skip;
            cnt++;
         end
         s.action  = IDX_W'(a);
         s.units   = UNIT_W'(cnt);
         s.is_last = 1'b0;
         expected_shares = {expected_shares, s};
         remain -= cnt;
      end
      s.action  = IDX_W'(acts - 1);
      s.units   = UNIT_W'(remain);
      s.is_last = 1'b1;
      expected_shares = {expected_shares, s};
   endtask

   task automatic note_error(input string what, input share_type want, input share_type got);
      error_count++;
      if (error_count <= 10)
         $display({"ERROR %0t: %s: expected action %0d units %0d last %0b, ",
                   "got action %0d units %0d last %0b"},
                  $realtime, what, want.action, want.units, want.is_last,
                  got.action, got.units, got.is_last);
   endtask

   always @(posedge clock) begin
      share_type got;
      share_type want;
      if (reset) begin
         unit_total  = UNIT_W'(1);
         error_count = 0;
         expected_shares.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rsp_action_index, rsp_unit_count, rsp_last_action};
            if (expected_shares.size() == 0) begin
               note_error("unexpected transfer", '0, got);
            end else begin
               want = expected_shares.pop_front();
               if (got !== want) note_error("mismatch", want, got);
            end
         end
         if (start && !busy) split_units(req_rank_code, req_action_count);
         if (csr_wr_en) unit_total = csr_wr_data;
      end
      pending_count <= expected_shares.size();
   end

endmodule

### dv/composition_code_unrank_tb.sv
// Testbench top for the composition unranker: stimulus, register writes and verdict.
module composition_code_unrank_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ccu_pkg::*;

   localparam longint unsigned BINOM_CAP = 64'd1 << CODE_W;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [CODE_W-1:0] req_rank_code    = '0;
   logic [ACT_W-1:0]  req_action_count = '0;
   logic              rsp_valid;
   logic [IDX_W-1:0]  rsp_action_index;
   logic [UNIT_W-1:0] rsp_unit_count;
   logic              rsp_last_action;
   logic              csr_wr_en        = 1'b0;
   logic [UNIT_W-1:0] csr_wr_data      = '0;

   int                error_count;
   int                pending_count;
   int                idle_pct         = 0;
   logic [UNIT_W-1:0] cur_total        = UNIT_W'(1);
   int                probe_acts[4]    = '{2, 3, 5, 8};

   composition_code_unrank DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_rank_code    (req_rank_code),
      .req_action_count (req_action_count),
      .rsp_valid        (rsp_valid),
      .rsp_action_index (rsp_action_index),
      .rsp_unit_count   (rsp_unit_count),
      .rsp_last_action  (rsp_last_action),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   composition_code_unrank_checker share_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_rank_code    (req_rank_code),
      .req_action_count (req_action_count),
      .rsp_valid        (rsp_valid),
      .rsp_action_index (rsp_action_index),
      .rsp_unit_count   (rsp_unit_count),
      .rsp_last_action  (rsp_last_action),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always #10 clock = ~clock;

   // number of compositions of total over acts actions, capped like the codes
   function automatic longint unsigned composition_total(input logic [UNIT_W-1:0] total,
                                                         input logic [ACT_W-1:0]  acts);
      longint unsigned units;
      longint unsigned k;
      longint unsigned acc;
      units = (total > MAX_UNITS) ? 64'(MAX_UNITS) : 64'(total);
      k     = (acts < 1) ? 64'(0) : (acts > ACTION_LIMIT) ? 64'(ACTION_LIMIT - 1)
                                                            : 64'(acts - 1);
      acc   = 1;
      for (longint unsigned i = 1; i <= k; i++) begin
         acc = acc * (units + i) / i;
         if (acc > BINOM_CAP) acc = BINOM_CAP;
      end
      return acc;
   endfunction

   task automatic send_request(input logic [CODE_W-1:0] code, input logic [ACT_W-1:0] acts);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_rank_code    <= code;
      req_action_count <= acts;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending_count != 0);
   endtask

   task automatic write_total(input logic [UNIT_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cur_total    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random();
      logic [ACT_W-1:0] acts;
      longint unsigned  bound;
      longint unsigned  code;
      int               pick;
      if ($urandom_range(0, 9) == 0)
         acts = $urandom_range(0, 1) ? ACT_W'(0)
                                     : ACT_W'($urandom_range(ACTION_LIMIT + 1, (1 << ACT_W) - 1));
      else
         acts = ACT_W'($urandom_range(1, ACTION_LIMIT));
      bound = composition_total(cur_total, acts);
      code  = {$urandom, $urandom};
      pick  = $urandom_range(0, 99);
      if (pick < 70)
         code = code % bound;
      else if (pick < 80)
         code = bound - 1 + $urandom_range(0, 1);
      send_request(CODE_W'(code), acts);
   endtask

   initial begin
      longint unsigned bound;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // unit total at its reset value
      send_request('0, ACT_W'(1));
      send_request('1, ACT_W'(ACTION_LIMIT));
      send_request(CODE_W'(3), ACT_W'(0));
      send_request(CODE_W'(1), '1);

      // small total: rank boundaries, codes past the end, clamped action count
      write_total(UNIT_W'(6));
      foreach (probe_acts[i]) begin
         bound = composition_total(cur_total, ACT_W'(probe_acts[i]));
         send_request(CODE_W'(bound - 1), ACT_W'(probe_acts[i]));
         send_request(CODE_W'(bound), ACT_W'(probe_acts[i]));
      end
      send_request('0, ACT_W'(ACTION_LIMIT + 1));
      send_request('1, ACT_W'(4));

      // zero total
      write_total('0);
      send_request(CODE_W'(5), ACT_W'(3));
      send_request('0, ACT_W'(ACTION_LIMIT));

      // largest total
      write_total(UNIT_W'(MAX_UNITS));
      bound = composition_total(cur_total, ACT_W'(ACTION_LIMIT));
      send_request('0, ACT_W'(ACTION_LIMIT));
      send_request(CODE_W'(bound - 1), ACT_W'(ACTION_LIMIT));
      send_request('1, ACT_W'(2));

      // total above the limit saturates
      write_total('1);
      send_request(CODE_W'({$urandom, $urandom}), ACT_W'(ACTION_LIMIT));
      send_request('0, ACT_W'(1));

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            3:       write_total(UNIT_W'(MAX_UNITS));
            7:       write_total(UNIT_W'($urandom_range(MAX_UNITS + 1, (1 << UNIT_W) - 1)));
            9:       write_total(UNIT_W'(1));
            default: write_total(UNIT_W'($urandom_range(2, 48)));
         endcase
         case (phase % 4)
            1:       idle_pct = 71;
            3:       idle_pct = 24;
            default: idle_pct = 0;
         endcase
         repeat (25) send_random();
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #100ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
rtl/ccu_pkg.sv
rtl/composition_code_unrank.sv
rtl/ccu_checker.sv
dv/composition_code_unrank_checker.sv
dv/composition_code_unrank_tb.sv
